@@ rtl/core/srlh_pkg.sv @@
`timescale 1ns / 1ps

package srlh_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_FLUSH   = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam int CMD_W   = 2;
    localparam int START_W = 48;
    localparam int LEN_W   = 16;
    localparam int IDX_W   = 6;
    localparam int COUNT_W = 32;
    localparam int TOTAL_W = 48;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // result buffer depth, covers the histogram read stage plus two waiting results
    localparam int FIFO_DEPTH = 3;

    typedef struct packed {
        logic valid;
        logic is_read;
    } op_ctrl_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_blocks;
        logic [COUNT_W-1:0] bin_count;
    } result_t;

endpackage

@@ rtl/core/srlh_hist.sv @@
`timescale 1ns / 1ps

module srlh_hist
    import srlh_pkg::*;
#(
    parameter int DEPTH = 128,
    localparam int SLOT_W = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  op_ctrl_t            op_ctrl,
    input  logic [SLOT_W-1:0]   op_slot,
    input  logic [TOTAL_W-1:0]  op_total,
    output logic                clr_busy,
    output logic                pending_read,
    output logic                res_valid,
    output result_t             res
);

    logic [COUNT_W-1:0] hist_mem [DEPTH];

    logic [COUNT_W-1:0] rd_data_reg;
    op_ctrl_t           s1_ctrl_reg;
    logic [SLOT_W-1:0]  s1_slot_reg;
    logic [TOTAL_W-1:0] s1_total_reg;

    logic               wb_valid_reg;
    logic [SLOT_W-1:0]  wb_slot_reg;
    logic [COUNT_W-1:0] wb_data_reg;

    logic               clr_active_reg;
    logic [SLOT_W-1:0]  clr_addr_reg;

    logic [COUNT_W-1:0] cur_count;
    logic [COUNT_W-1:0] inc_count;
    logic               s1_inc;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [COUNT_W-1:0] wr_data;

    // the write of the op just ahead is not yet visible in rd_data_reg
    assign cur_count = (wb_valid_reg && wb_slot_reg == s1_slot_reg) ? wb_data_reg : rd_data_reg;
    assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1);
    assign s1_inc    = s1_ctrl_reg.valid && !s1_ctrl_reg.is_read;

    assign wr_en   = clr_active_reg || s1_inc;
    assign wr_addr = clr_active_reg ? clr_addr_reg : s1_slot_reg;
    assign wr_data = clr_active_reg ? '0 : inc_count;

    assign clr_busy     = clr_active_reg;
    assign pending_read = s1_ctrl_reg.valid && s1_ctrl_reg.is_read;
    assign res_valid    = pending_read;
    assign res.bin_count    = cur_count;
    assign res.total_blocks = s1_total_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= hist_mem[op_slot];
    end

    always_ff @(posedge aclk) begin
        s1_slot_reg  <= op_slot;
        s1_total_reg <= op_total;
        wb_slot_reg  <= s1_slot_reg;
        wb_data_reg  <= inc_count;
        if (!aresetn) begin
            s1_ctrl_reg    <= '0;
            wb_valid_reg   <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else begin
            s1_ctrl_reg  <= op_ctrl;
            wb_valid_reg <= s1_inc;
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + SLOT_W'(1);
                if (clr_addr_reg == SLOT_W'(DEPTH - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
        end
    end

    a_no_op_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        op_ctrl.valid |-> !clr_active_reg)
        else $error("histogram op issued during clearing pass");

    a_inc_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_inc && !clr_active_reg) |-> wr_data != '0)
        else $error("histogram increment wrote zero");

endmodule

@@ rtl/core/srlh_out_fifo.sv @@
`timescale 1ns / 1ps

module srlh_out_fifo
    import srlh_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  result_t                    in_data,
    output logic [1:0]                 occupancy,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [COUNT_W+TOTAL_W-1:0] m_tdata
);

    result_t    entry_reg [FIFO_DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop       = m_tvalid && m_tready;
    assign m_tvalid  = count_reg != 2'd0;
    assign m_tdata   = entry_reg[rd_ptr_reg];
    assign occupancy = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_valid) begin
            wr_ptr_next = (wr_ptr_reg == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;
        end
        if (in_valid && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (!in_valid && pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |-> (count_reg != 2'(FIFO_DEPTH) || pop))
        else $error("result buffer overflow");

endmodule

@@ rtl/core/sequential_run_length_histogram_unit.sv @@
`timescale 1ns / 1ps

// sequential run-length histogram for a stream of block i/o commands
//
// s_ channel: one command per transaction; s_tuser carries the command
// (request, flush, read bin), s_tdata the direction, start block, block
// count and bin index. requests and flushes produce nothing on the m_ side.
// m_ channel: one transaction per read command, carrying the bin count and
// the running block total seen at the moment the read was accepted.
//
// throughput: one transaction per cycle while s_tready is high, any mix of commands. run tracking
// lives in registers, the 2*BINS x 32 histogram in a one-port-read memory
// that is updated read-modify-write with forwarding from the previous write.
// read path: a read result reaches m_ through the memory read register, then
// through the result buffer.
// reset: the run state clears at once, then a clearing pass zeroes the
// histogram, one entry a cycle, across all 2*BINS entries with s_tready low.
// stall: a three-entry result buffer decouples m_tready; s_tready drops when
// buffered plus in-flight reads fill it, and during the clearing pass.
module sequential_run_length_histogram_unit
    import srlh_pkg::*;
#(
    parameter int BINS            = 64,
    parameter int BLOCK_ADDR_BITS = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [0] is_write, [48:1] start_block, [64:49] block_count, [70:65] bin_index, [71] zero
    input  logic [71:0]  s_tdata,
    // [1:0] command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] bin_count, [79:32] total_blocks
    output logic [79:0]  m_tdata
);

    localparam int ABITS  = BLOCK_ADDR_BITS;
    localparam int EXT_W  = (ABITS > START_W) ? ABITS : START_W;
    localparam int DEPTH  = 2 * BINS;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int BIN_W  = $clog2(BINS);

    // field unpacking
    logic                accept;
    logic [CMD_W-1:0]    cmd;
    logic                is_write;
    logic [START_W-1:0]  start_block;
    logic [LEN_W-1:0]    block_count;
    logic [IDX_W-1:0]    bin_index;

    // run tracking state
    logic                run_open_reg,    run_open_next;
    logic [ABITS-1:0]    last_end_reg,    last_end_next;
    logic                last_wr_reg,     last_wr_next;
    logic [TOTAL_W-1:0]  run_length_reg,  run_length_next;
    logic [TOTAL_W-1:0]  blocks_seen_reg, blocks_seen_next;

    logic [EXT_W-1:0]    start_ext;
    logic [ABITS-1:0]    start_a;
    logic [ABITS-1:0]    end_a;
    logic                cont;
    logic [TOTAL_W:0]    run_sum;
    logic [TOTAL_W:0]    seen_sum;
    logic [TOTAL_W-1:0]  run_sat;
    logic [TOTAL_W-1:0]  seen_sat;
    logic [BIN_W-1:0]    run_bin;
    logic [31:0]         idx_bin32;
    logic [BIN_W-1:0]    read_bin;
    logic [SLOT_W-1:0]   run_slot;
    logic [SLOT_W-1:0]   read_slot;

    // histogram op toward the memory stage
    op_ctrl_t            op_ctrl;
    logic [SLOT_W-1:0]   op_slot;
    logic                clr_busy;
    logic                pending_read;
    logic                res_valid;
    result_t             res;
    logic [1:0]          occupancy;
    logic [2:0]          in_flight;

    assign accept      = s_tvalid && s_tready;
    assign cmd         = s_tuser;
    assign is_write    = s_tdata[0];
    assign start_block = s_tdata[48:1];
    assign block_count = s_tdata[64:49];
    assign bin_index   = s_tdata[70:65];

    // block addresses wrap at the configured address width
    assign start_ext = EXT_W'(start_block);
    assign start_a   = start_ext[ABITS-1:0];
    assign end_a     = start_a + ABITS'(block_count) - ABITS'(1);
    assign cont      = (last_wr_reg == is_write) && (start_a == last_end_reg + ABITS'(1));

    // saturating 48-bit sums
    assign run_sum  = {1'b0, run_length_reg} + (TOTAL_W + 1)'(block_count);
    assign seen_sum = {1'b0, blocks_seen_reg} + (TOTAL_W + 1)'(block_count);
    assign run_sat  = run_sum[TOTAL_W]  ? TOTAL_MAX : run_sum[TOTAL_W-1:0];
    assign seen_sat = seen_sum[TOTAL_W] ? TOTAL_MAX : seen_sum[TOTAL_W-1:0];

    // long runs fold into the last bin, write bins sit above read bins
    assign run_bin   = (run_length_reg >= TOTAL_W'(BINS - 1)) ? BIN_W'(BINS - 1)
                                                               : run_length_reg[BIN_W-1:0];
    assign run_slot  = SLOT_W'(run_bin) + (last_wr_reg ? SLOT_W'(BINS) : SLOT_W'(0));

    // out-of-range index reads the last bin
    assign idx_bin32 = (32'(bin_index) >= 32'(BINS)) ? 32'(BINS - 1) : 32'(bin_index);
    assign read_bin  = idx_bin32[BIN_W-1:0];
    assign read_slot = SLOT_W'(read_bin) + (is_write ? SLOT_W'(BINS) : SLOT_W'(0));

    always_comb begin
        run_open_next    = run_open_reg;
        last_end_next    = last_end_reg;
        last_wr_next     = last_wr_reg;
        run_length_next  = run_length_reg;
        blocks_seen_next = blocks_seen_reg;
        op_ctrl          = '0;
        op_slot          = read_slot;
        if (accept) begin
            case (cmd)
                CMD_REQUEST: begin
                    if (run_open_reg) begin
                        if (cont) begin
                            run_length_next = run_sat;
                        end else begin
                            // run broken: count it and start a new one
                            op_ctrl.valid   = 1'b1;
                            op_slot         = run_slot;
                            run_length_next = TOTAL_W'(block_count);
                        end
                    end else begin
                        run_open_next   = 1'b1;
                        run_length_next = TOTAL_W'(block_count);
                    end
                    last_wr_next     = is_write;
                    last_end_next    = end_a;
                    blocks_seen_next = seen_sat;
                end
                CMD_FLUSH: begin
                    // an empty run is dropped on flush
                    if (run_open_reg && run_length_reg != '0) begin
                        op_ctrl.valid = 1'b1;
                        op_slot       = run_slot;
                    end
                    run_open_next   = 1'b0;
                    run_length_next = '0;
                end
                CMD_READ: begin
                    op_ctrl.valid   = 1'b1;
                    op_ctrl.is_read = 1'b1;
                    op_slot         = read_slot;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_open_reg    <= 1'b0;
            last_end_reg    <= '0;
            last_wr_reg     <= 1'b0;
            run_length_reg  <= '0;
            blocks_seen_reg <= '0;
        end else begin
            run_open_reg    <= run_open_next;
            last_end_reg    <= last_end_next;
            last_wr_reg     <= last_wr_next;
            run_length_reg  <= run_length_next;
            blocks_seen_reg <= blocks_seen_next;
        end
    end

    // credit check: reserve a buffer slot for every read still in flight
    assign in_flight = 3'(occupancy) + 3'(pending_read);
    assign s_tready  = !clr_busy && (in_flight < 3'(FIFO_DEPTH));

    srlh_hist #(
        .DEPTH (DEPTH)
    ) u_hist (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op_ctrl      (op_ctrl),
        .op_slot      (op_slot),
        .op_total     (blocks_seen_reg),
        .clr_busy     (clr_busy),
        .pending_read (pending_read),
        .res_valid    (res_valid),
        .res          (res)
    );

    srlh_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .occupancy (occupancy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_closed_run_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !run_open_reg |-> run_length_reg == '0)
        else $error("closed run holds a nonzero length");

    a_read_reaches_memory: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == CMD_READ) |=> pending_read)
        else $error("accepted read command did not reach the histogram stage");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import srlh_pkg::*;

    localparam int TB_BINS   = 64;
    localparam int LIMIT     = 400000;
    localparam int RAND_ITEMS = 1280;
    // per-item command field, extra code that the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic               wr;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   count;
        logic [IDX_W-1:0]   idx;
    } io_cmd_t;

    // tracks open runs and both histograms, holds the expected bin readouts
    class run_hist_scoreboard;
        result_t            expected_readouts[$];
        int unsigned        errors;
        bit                 open_run;
        logic [START_W-1:0] prev_end;
        bit                 prev_write;
        logic [TOTAL_W-1:0] cur_run_len;
        logic [TOTAL_W-1:0] total_seen;
        logic [COUNT_W-1:0] run_bins[2*TB_BINS];

        function new();
            errors      = 0;
            open_run    = 0;
            prev_end    = '0;
            prev_write  = 0;
            cur_run_len = '0;
            total_seen  = '0;
            foreach (run_bins[i]) run_bins[i] = '0;
        endfunction

        function logic [TOTAL_W-1:0] sat_add(logic [TOTAL_W-1:0] a, logic [TOTAL_W-1:0] b);
            logic [TOTAL_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
        endfunction

        function int bin_slot(bit wr, logic [TOTAL_W-1:0] len);
            int bin;
            bin = (len < TB_BINS - 1) ? int'(len) : TB_BINS - 1;
            return bin + (wr ? TB_BINS : 0);
        endfunction

        function void tally_run(bit wr, logic [TOTAL_W-1:0] len);
            int slot;
            slot = bin_slot(wr, len);
            if (run_bins[slot] != COUNT_MAX) run_bins[slot]++;
        endfunction

        function int pending();
            return expected_readouts.size();
        endfunction

        function void record_command(io_cmd_t c);
            result_t r;
            case (c.cmd)
                CMD_REQUEST: begin
                    if (open_run) begin
                        if (c.wr == prev_write && c.start == prev_end + 1'b1) begin
                            cur_run_len = sat_add(cur_run_len, TOTAL_W'(c.count));
                        end else begin
                            tally_run(prev_write, cur_run_len);
                            cur_run_len = TOTAL_W'(c.count);
                        end
                    end else begin
                        open_run    = 1;
                        cur_run_len = TOTAL_W'(c.count);
                    end
                    prev_write = c.wr;
                    prev_end   = c.start + START_W'(c.count) - 1'b1;   // wraps
                    total_seen = sat_add(total_seen, TOTAL_W'(c.count));
                end
                CMD_FLUSH: begin
                    if (open_run && cur_run_len != 0) tally_run(prev_write, cur_run_len);
                    open_run    = 0;
                    cur_run_len = '0;
                end
                CMD_READ: begin
                    // index clamp to the last bin, same slot rule as a long run
                    r.bin_count    = run_bins[bin_slot(c.wr, TOTAL_W'(c.idx))];
                    r.total_blocks = total_seen;
                    expected_readouts.insert(expected_readouts.size(), r);
                end
                default: ;
            endcase
        endfunction

        function void check_readout(logic [COUNT_W-1:0] bin_count,
                                    logic [TOTAL_W-1:0] total_blocks);
            result_t e;
            if (expected_readouts.size() == 0) begin
                $display("%0t: unexpected result bin_count=%0d total_blocks=%0d",
                         $time, bin_count, total_blocks);
                errors++;
                return;
            end
            e = expected_readouts.pop_front();
            if (bin_count !== e.bin_count) begin
                $display("%0t: bin_count mismatch expected=%0d actual=%0d",
                         $time, e.bin_count, bin_count);
                errors++;
            end
            if (total_blocks !== e.total_blocks) begin
                $display("%0t: total_blocks mismatch expected=%0d actual=%0d",
                         $time, e.total_blocks, total_blocks);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    run_hist_scoreboard sb = new();
    bit                 quiet;          // no idling on either side while set
    int unsigned        cycle_count;
    io_cmd_t            seen_cmd;

    sequential_run_length_histogram_unit #(
        .BINS            (TB_BINS),
        .BLOCK_ADDR_BITS (START_W)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // both channels sampled at the edge, before any driver update lands
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            seen_cmd.cmd   = s_tuser;
            seen_cmd.wr    = s_tdata[0];
            seen_cmd.start = s_tdata[48:1];
            seen_cmd.count = s_tdata[64:49];
            seen_cmd.idx   = s_tdata[70:65];
            sb.record_command(seen_cmd);
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_readout(m_tdata[31:0], m_tdata[79:32]);
        end
    end

    // receiver stalls about a third of the time outside the quiet stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 35);
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("sequential_run_length_histogram_unit regression: fail");
        $finish;
    end

    task automatic send_cmd(io_cmd_t c);
        if (!quiet && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.cmd;
        s_tdata  <= {1'b0, c.idx, c.count, c.start, c.wr};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_fields(logic [CMD_W-1:0] cmd, logic wr, logic [START_W-1:0] start,
                               logic [LEN_W-1:0] count, logic [IDX_W-1:0] idx);
        io_cmd_t c;
        c.cmd   = cmd;
        c.wr    = wr;
        c.start = start;
        c.count = count;
        c.idx   = idx;
        send_cmd(c);
    endtask

    // sender holds off until every outstanding readout has come back
    task automatic drain_readouts();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    function automatic logic [START_W-1:0] rand_block();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[START_W-1:0];
    endfunction

    initial begin : stimulus
        io_cmd_t            c;
        logic [START_W-1:0] gen_end;
        bit                 gen_wr;
        int                 p;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_REQUEST;
        quiet    = 0;
        gen_end  = '0;
        gen_wr   = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // cleared histograms read back as zero, both directions, lowest and highest bin
        send_fields(CMD_READ, 1'b0, '0, '0, '0);
        send_fields(CMD_READ, 1'b1, '1, '1, '1);
        // zero-length request ends one block below its start, so block 0 continues it
        send_fields(CMD_REQUEST, 1'b0, '0, 16'd0, '0);
        send_fields(CMD_REQUEST, 1'b0, '0, 16'd5, '0);
        // longest request, run goes past the last bin
        send_fields(CMD_REQUEST, 1'b0, 48'd5, 16'hFFFF, '0);
        // direction change breaks the run; this write run wraps past the top block
        send_fields(CMD_REQUEST, 1'b1, TOTAL_MAX, 16'd2, '0);
        send_fields(CMD_REQUEST, 1'b1, 48'd1, 16'd3, '0);
        send_fields(CMD_FLUSH, 1'b0, '1, '1, '1);
        // flush with no open run does nothing
        send_fields(CMD_FLUSH, 1'b1, '0, '0, '0);
        // zero-length run broken by a far request lands in bin zero
        send_fields(CMD_REQUEST, 1'b0, 48'd100, 16'd0, '0);
        send_fields(CMD_REQUEST, 1'b0, 48'd500, 16'd1, '0);
        // unused command code, ignored
        send_fields(CMD_UNUSED, 1'b1, '1, '1, '1);
        send_fields(CMD_FLUSH, 1'b0, '0, '0, '0);
        // flushing a run of length zero counts nothing
        send_fields(CMD_REQUEST, 1'b1, 48'd7, 16'd0, '0);
        send_fields(CMD_FLUSH, 1'b1, '0, '0, '0);
        // same start, same direction but not adjacent
        send_fields(CMD_REQUEST, 1'b1, 48'h8000_0000_0000, 16'd4, '0);
        send_fields(CMD_REQUEST, 1'b1, 48'h8000_0000_0000, 16'd4, '0);
        send_fields(CMD_FLUSH, 1'b1, '0, '0, '0);
        send_fields(CMD_READ, 1'b0, '0, '0, 6'd63);
        send_fields(CMD_READ, 1'b1, '0, '0, 6'd5);
        send_fields(CMD_READ, 1'b0, '0, '0, 6'd0);
        send_fields(CMD_READ, 1'b0, '0, '0, 6'd1);
        send_fields(CMD_READ, 1'b1, '0, '0, 6'd2);
        send_fields(CMD_READ, 1'b1, '0, '0, 6'd4);
        send_fields(CMD_READ, 1'b1, '0, '0, 6'd63);
        drain_readouts();

        // mostly sequential streams with short requests, some breaks, flushes and reads
        for (int n = 0; n < RAND_ITEMS; n++) begin
            quiet = (n >= 450 && n < 750);
            if (n == 900) drain_readouts();
            c.wr    = 1'($urandom_range(1));
            c.start = rand_block();
            c.count = LEN_W'($urandom_range(0, 16'hFFFF));
            c.idx   = IDX_W'($urandom_range(0, 63));
            p = $urandom_range(99);
            if (p < 14) begin
                c.cmd = CMD_READ;
                if ($urandom_range(3) != 0) c.idx = IDX_W'($urandom_range(0, 14));
                if ($urandom_range(9) == 0) c.idx = 6'd63;
            end else if (p < 21) begin
                c.cmd = CMD_FLUSH;
            end else if (p < 23) begin
                c.cmd = CMD_UNUSED;
            end else begin
                c.cmd = CMD_REQUEST;
                p = $urandom_range(99);
                if (p < 72) begin
                    c.wr    = gen_wr;
                    c.start = gen_end + 1'b1;
                end else if (p < 82) begin
                    // adjacent block, other direction
                    c.wr    = !gen_wr;
                    c.start = gen_end + 1'b1;
                end else if (p < 87) begin
                    c.start = TOTAL_MAX - START_W'($urandom_range(0, 3));
                end
                p = $urandom_range(99);
                if (p < 3)      c.count = LEN_W'($urandom_range(0, 16'hFFFF));
                else if (p < 4) c.count = 16'hFFFF;
                else            c.count = LEN_W'($urandom_range(0, 5));
                gen_wr  = c.wr;
                gen_end = c.start + START_W'(c.count) - 1'b1;
            end
            send_cmd(c);
        end
        quiet = 0;

        drain_readouts();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("sequential_run_length_histogram_unit regression: pass");
        end else begin
            $display("sequential_run_length_histogram_unit regression: fail");
        end
        $finish;
    end

endmodule
